>>> rtl/rfc_pkg.sv
// Package for the ray frustum clip range block: types, widths and constants.
package rfc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_PLANES    = 6;
    localparam int CS_W          = 33;
    localparam int REM_W         = 64;
    localparam int QBITS         = 31;
    localparam int Q_W           = QBITS + 1;
    localparam int T_W           = 31;
    // plane setup, divider setup, QBITS divider steps, sign apply, reduce
    localparam int PIPE_LAT      = QBITS + 4;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] origin_w;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] dir_w;
    } ray_t;

    typedef struct packed {
        logic           visible;
        logic [T_W-1:0] t_start;
        logic [T_W-1:0] t_end;
    } clip_result_t;

    typedef struct packed {
        logic signed [CS_W-1:0] c;
        logic signed [CS_W-1:0] s;
    } plane_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [CS_W-1:0]  den;
        logic [Q_W-1:0]   quo;
        logic             zero_s;
        logic             neg_s;
        logic             neg_c;
        logic             neg_t;
    } div_lane_t;

    typedef struct packed {
        logic signed [CS_W-1:0] t;
        logic                   zero_s;
        logic                   neg_s;
        logic                   neg_c;
    } cross_t;

endpackage

>>> rtl/ray_frustum_clip_range.sv
// Top level: pipelined clip of a homogeneous ray against the six frustum planes.
//
// Takes one ray per clock on start (busy is always low) and returns one word on
// done for each ray, in order; the receiver cannot stall. Most of the pipeline
// is six parallel restoring dividers, one quotient bit per stage,
// with crossings saturated at 2^31 since anything larger is rejected anyway.
module ray_frustum_clip_range #(
    parameter int FRAC_BITS = rfc_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rfc_pkg::ray_t         ray,
    output logic                  done,
    output rfc_pkg::clip_result_t result
);

    localparam int NP = rfc_pkg::NUM_PLANES;
    localparam int QB = rfc_pkg::QBITS;
    localparam int RW = rfc_pkg::REM_W;
    localparam int CW = rfc_pkg::CS_W;

    // stage valid bits: [0] plane, [1..QB+1] divider, [QB+2] sign, [QB+3] output
    logic [rfc_pkg::PIPE_LAT-1:0] vld_reg;
    logic [rfc_pkg::PIPE_LAT-1:0] vld_next;

    rfc_pkg::plane_t      plane_reg [NP];
    rfc_pkg::plane_t      plane_next [NP];
    rfc_pkg::div_lane_t   div_reg [QB+1][NP];
    rfc_pkg::div_lane_t   div_next [QB+1][NP];
    rfc_pkg::cross_t      cross_reg [NP];
    rfc_pkg::cross_t      cross_next [NP];
    rfc_pkg::clip_result_t result_reg;
    rfc_pkg::clip_result_t result_next;

    assign busy   = 1'b0;
    assign done   = vld_reg[rfc_pkg::PIPE_LAT-1];
    assign result = result_reg;

    // valid bits travel with the word
    assign vld_next = {vld_reg[rfc_pkg::PIPE_LAT-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // plane constants and slopes, exact in 33 bits
    always_comb
    begin
        logic signed [CW-1:0] ox, oy, oz, ow, dx, dy, dz, dw;
        ox = {ray.origin_x[31], ray.origin_x};
        oy = {ray.origin_y[31], ray.origin_y};
        oz = {ray.origin_z[31], ray.origin_z};
        ow = {ray.origin_w[31], ray.origin_w};
        dx = {ray.dir_x[31], ray.dir_x};
        dy = {ray.dir_y[31], ray.dir_y};
        dz = {ray.dir_z[31], ray.dir_z};
        dw = {ray.dir_w[31], ray.dir_w};
        plane_next[0] = '{c: ow + ox, s: dw + dx};
        plane_next[1] = '{c: ow - ox, s: dw - dx};
        plane_next[2] = '{c: ow + oy, s: dw + dy};
        plane_next[3] = '{c: ow - oy, s: dw - dy};
        plane_next[4] = '{c: oz,      s: dz};
        plane_next[5] = '{c: ow - oz, s: dw - dz};
    end

    // divider setup: magnitudes, saturation check
    always_comb
    begin
        logic [CW-1:0] mag_c;
        logic [RW-1:0] dvd;
        logic          sat;
        for (int p = 0; p < NP; p++)
        begin
            mag_c = plane_reg[p].c[CW-1] ? (~plane_reg[p].c + 1'b1) : plane_reg[p].c;
            div_next[0][p].den    = plane_reg[p].s[CW-1] ? (~plane_reg[p].s + 1'b1)
                                                         : plane_reg[p].s;
            div_next[0][p].zero_s = (plane_reg[p].s == '0);
            div_next[0][p].neg_s  = plane_reg[p].s[CW-1];
            div_next[0][p].neg_c  = plane_reg[p].c[CW-1];
            div_next[0][p].neg_t  = ~(plane_reg[p].c[CW-1] ^ plane_reg[p].s[CW-1]);
            dvd = RW'(mag_c) << FRAC_BITS;
            sat = (dvd >= (RW'(div_next[0][p].den) << QB));
            div_next[0][p].quo = sat ? {1'b1, {QB{1'b0}}} : '0;
            div_next[0][p].rem = (sat || div_next[0][p].zero_s) ? '0 : dvd;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < QB; j++)
    begin : g_div
        always_comb
        begin
            logic [RW-1:0] trial;
            for (int p = 0; p < NP; p++)
            begin
                div_next[j+1][p] = div_reg[j][p];
                trial = RW'(div_reg[j][p].den) << (QB - 1 - j);
                if (!div_reg[j][p].zero_s && (div_reg[j][p].rem >= trial))
                begin
                    div_next[j+1][p].rem          = div_reg[j][p].rem - trial;
                    div_next[j+1][p].quo[QB-1-j] = 1'b1;
                end
            end
        end
    end

    // signed crossing parameter
    always_comb
    begin
        logic signed [CW-1:0] q;
        for (int p = 0; p < NP; p++)
        begin
            q = {1'b0, div_reg[QB][p].quo};
            cross_next[p].t      = div_reg[QB][p].neg_t ? -q : q;
            cross_next[p].zero_s = div_reg[QB][p].zero_s;
            cross_next[p].neg_s  = div_reg[QB][p].neg_s;
            cross_next[p].neg_c  = div_reg[QB][p].neg_c;
        end
    end

    // interval reduce and final checks
    always_comb
    begin
        logic signed [CW-1:0] st;
        logic signed [CW-1:0] en;
        logic                 bnd;
        logic                 bad;
        logic                 ok;
        st  = '0;
        en  = '0;
        bnd = 1'b0;
        bad = 1'b0;
        for (int p = 0; p < NP; p++)
        begin
            if (cross_reg[p].zero_s)
            begin
                bad = bad | cross_reg[p].neg_c;
            end
            else if (!cross_reg[p].neg_s)
            begin
                if (cross_reg[p].t > st)
                begin
                    st = cross_reg[p].t;
                end
            end
            else
            begin
                if (!bnd || (cross_reg[p].t < en))
                begin
                    en = cross_reg[p].t;
                end
                bnd = 1'b1;
            end
        end
        ok = !bad && bnd && (en <= $signed({2'b00, {rfc_pkg::T_W{1'b1}}})) && (st < en);
        result_next.visible = ok;
        result_next.t_start = ok ? st[rfc_pkg::T_W-1:0] : '0;
        result_next.t_end   = ok ? en[rfc_pkg::T_W-1:0] : '0;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        plane_reg  <= plane_next;
        div_reg    <= div_next;
        cross_reg  <= cross_next;
        result_reg <= result_next;
    end

endmodule

>>> rtl/rfc_checker.sv
// Port checker for the ray frustum clip range block, with its bind.
module rfc_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input rfc_pkg::ray_t         ray,
    input logic                  done,
    input rfc_pkg::clip_result_t result
);

    // never refuses a word
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // each result word follows an accepted ray at fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, rfc_pkg::PIPE_LAT))
        else $error("result without matching ray");

    // rejected rays carry a zero interval
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.visible) |-> (result.t_start == '0 && result.t_end == '0))
        else $error("rejected ray with nonzero interval");

    // visible interval is nonempty
    a_interval: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.visible) |-> (result.t_start < result.t_end))
        else $error("visible interval empty");

endmodule

bind ray_frustum_clip_range rfc_checker u_rfc_checker (.*);

>>> tb/rfc_checker.sv
// Checker for the ray frustum clip block: predicts each clip result and compares.
`timescale 1ns / 100ps

module rfc_scoreboard (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  rfc_pkg::ray_t         ray,
    input  logic                  done,
    input  rfc_pkg::clip_result_t result,
    output int                    fail_count,
    output int                    pending
);

    localparam longint T_LIMIT = 64'sd2147483647;

    rfc_pkg::clip_result_t expected_clips[$];

    // Clip the ray parameter t >= 0 against the six frustum planes
    function automatic rfc_pkg::clip_result_t predict_clip(rfc_pkg::ray_t r);
        longint ox, oy, oz, ow, dx, dy, dz, dw;
        longint c_tab[6];
        longint s_tab[6];
        longint t_lo, t_hi, t;
        bit     hi_set, keep;
        rfc_pkg::clip_result_t res;
        ox = r.origin_x; oy = r.origin_y; oz = r.origin_z; ow = r.origin_w;
        dx = r.dir_x;    dy = r.dir_y;    dz = r.dir_z;    dw = r.dir_w;
        c_tab[0] = ow + ox; s_tab[0] = dw + dx;
        c_tab[1] = ow - ox; s_tab[1] = dw - dx;
        c_tab[2] = ow + oy; s_tab[2] = dw + dy;
        c_tab[3] = ow - oy; s_tab[3] = dw - dy;
        c_tab[4] = oz;      s_tab[4] = dz;
        c_tab[5] = ow - oz; s_tab[5] = dw - dz;
        t_lo   = 0;
        t_hi   = 0;
        hi_set = 0;
        keep   = 1;
        for (int i = 0; i < rfc_pkg::NUM_PLANES && keep; i++)
        begin
            if (s_tab[i] == 0)
            begin
                // parallel plane: fully in or fully out
                keep = (c_tab[i] >= 0);
            end
            else
            begin
                t = (-c_tab[i] * (64'sd1 <<< rfc_pkg::FRAC_BITS_DEF)) / s_tab[i];
                if (s_tab[i] > 0)
                begin
                    if (t > t_lo)
                        t_lo = t;
                end
                else
                begin
                    if (!hi_set || t < t_hi)
                        t_hi = t;
                    hi_set = 1;
                end
                if (hi_set && t_lo > t_hi)
                    keep = 0;
            end
        end
        // unbounded, out of t range, or empty interval
        if (keep && (!hi_set || t_hi > T_LIMIT || t_lo >= t_hi))
            keep = 0;
        res = '0;
        if (keep)
        begin
            res.visible = 1'b1;
            res.t_start = t_lo[rfc_pkg::T_W-1:0];
            res.t_end   = t_hi[rfc_pkg::T_W-1:0];
        end
        return res;
    endfunction

    assign pending = expected_clips.size();

    // Queue on accepted word, compare on each done strobe
    always @(posedge clk or negedge rst_n)
    begin
        rfc_pkg::clip_result_t exp_r;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_clips.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_clips.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result word %p", result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_clips.pop_front();
                    if (result.visible !== exp_r.visible ||
                        result.t_start !== exp_r.t_start ||
                        result.t_end !== exp_r.t_end)
                    begin
                        if (fail_count < 10)
                            $display({"ERROR: mismatch exp vis=%0d ts=%h te=%h",
                                      " got vis=%0d ts=%h te=%h"},
                                     exp_r.visible, exp_r.t_start, exp_r.t_end,
                                     result.visible, result.t_start, result.t_end);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_clips.push_back(predict_clip(ray));
        end
    end

endmodule

>>> tb/tb_top.sv
// Testbench top: drives rays into the clip block and reports the verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_RAYS    = 1900;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    rfc_pkg::ray_t         ray;
    logic                  done;
    rfc_pkg::clip_result_t result;
    int                    fail_count;
    int                    pending;
    int                    idle_pct;
    int                    stall_cycles;

    ray_frustum_clip_range dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .ray    (ray),
        .done   (done),
        .result (result)
    );

    rfc_scoreboard chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .ray        (ray),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: cycles with no word moving either way
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int sym_rand(int mag);
        return int'($urandom_range(2 * mag)) - mag;
    endfunction

    // Present one word; idle cycles are inserted before it at the current rate
    task automatic send_ray(rfc_pkg::ray_t r);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        ray   <= r;
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_raw(int ox, int oy, int oz, int ow, int dx, int dy, int dz, int dw);
        rfc_pkg::ray_t r;
        r = '{ox, oy, oz, ow, dx, dy, dz, dw};
        send_ray(r);
    endtask

    // Origin inside the frustum, small direction: reaches the visible cases
    function automatic rfc_pkg::ray_t inside_ray();
        rfc_pkg::ray_t r;
        int w, dmag;
        w    = $urandom_range(1 << 20, 1 << 12);
        dmag = ($urandom_range(3) == 0) ? (1 << 24) : (1 << 17);
        r.origin_w = w;
        r.origin_x = sym_rand(w - 1);
        r.origin_y = sym_rand(w - 1);
        r.origin_z = $urandom_range(w - 1, 1);
        r.dir_x = ($urandom_range(7) == 0) ? 0 : sym_rand(dmag);
        r.dir_y = ($urandom_range(7) == 0) ? 0 : sym_rand(dmag);
        r.dir_z = ($urandom_range(7) == 0) ? 0 : sym_rand(dmag);
        r.dir_w = ($urandom_range(3) == 0) ? sym_rand(dmag) : -int'($urandom_range(dmag, 1));
        return r;
    endfunction

    function automatic rfc_pkg::ray_t noise_ray();
        rfc_pkg::ray_t r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return r;
    endfunction

    initial
    begin
        rfc_pkg::ray_t r;
        start    = 1'b0;
        ray      = '0;
        rst_n    = 1'b0;
        idle_pct = 16;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, parallel planes, unbounded, out of range, point cases
        send_raw(0, 0, 0, 0, 0, 0, 0, 0);
        send_raw(-1, -1, -1, -1, -1, -1, -1, -1);
        send_raw(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_raw(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_raw(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_raw(0, 0, 32'h8000, 32'h10000, 0, 0, 0, -32'h10000);
        send_raw(0, 0, 32'h8000, 32'h10000, 0, 0, 0, 0);
        send_raw(0, 0, 32'h8000, 32'h10000, 0, 0, 0, -1);
        send_raw(-32'h20000, 0, 32'h8000, 32'h10000, 32'h10000, 0, 0, 0);
        send_raw(32'h20000, 0, 32'h8000, 32'h10000, 0, 0, 0, 0);
        send_raw(0, 0, -32'h8000, 32'h10000, 0, 0, 32'h10000, -32'h10000);
        send_raw(0, 0, 0, 0, 0, 0, 32'h10000, -32'h10000);
        send_raw(0, 0, 32'h8000, 32'h10000, 32'h7fffffff, 0, 0, 32'h80000000);
        send_raw(32'h7fffffff, 0, 1, 32'h7fffffff, 32'h80000000, 0, 0, 32'h80000000);
        send_raw(0, 0, 32'h8000, 32'h10000, 0, 0, 0, -32'h7fffffff);
        send_raw(0, 0, 1, 1, 0, 0, 0, -1);
        for (int i = 0; i < 6; i++)
        begin
            r = inside_ray();
            send_ray(r);
        end

        // Random: three idling phases, each drained before the next
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 16 : (ph == 1) ? 65 : 0;
            for (int i = 0; i < RANDOM_RAYS / 3; i++)
            begin
                r = ($urandom_range(99) < 70) ? inside_ray() : noise_ray();
                send_ray(r);
            end
            // hold off until the pipe has emptied
            @(negedge clk);
            start <= 1'b0;
            while (pending != 0)
                @(negedge clk);
        end

        while (pending != 0)
            @(posedge clk);
        repeat (rfc_pkg::PIPE_LAT + 10) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/rfc_pkg.sv
rtl/ray_frustum_clip_range.sv
rtl/rfc_checker.sv
tb/rfc_checker.sv
tb/tb_top.sv
